@@ rtl/lfss_pkg.sv @@
// Shared types, codes and helpers for the line follow search sequencer.
`default_nettype none

package lfss_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CLAMP_W     = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic [CFG_W-1:0] SEARCH_TICKS_RESET = CFG_W'(200);
    localparam logic [CFG_W-1:0] PAUSE_TICKS_RESET  = CFG_W'(0);

    localparam logic REG_SEARCH_TICKS = 1'b0;
    localparam logic REG_PAUSE_TICKS  = 1'b1;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [CFG_W-1:0]       cfg_word_t;

    typedef enum logic [2:0] {
        PH_FOLLOW       = 3'd0,
        PH_SEARCH_LAST  = 3'd1,
        PH_RETURN_A     = 3'd2,
        PH_SEARCH_OTHER = 3'd3,
        PH_RETURN_B     = 3'd4,
        PH_SEARCH_FWD   = 3'd5,
        PH_PAUSE        = 3'd6,
        PH_HALTED       = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CMD_STOP    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_LEFT    = 2'd2,
        CMD_RIGHT   = 2'd3
    } cmd_t;

    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    typedef struct packed {
        phase_t phase;
        phase_t after_pause;
        logic   last_dir;
        timer_t tick;
    } state_t;

    typedef struct packed {
        cmd_t   cmd;
        phase_t phase;
        logic   halted;
    } result_t;

    // Saturates a register value to the largest count the timer can hold.
    function automatic timer_t clamp_target(input cfg_word_t v);
        logic [CLAMP_W-1:0] wide;
        logic [CLAMP_W-1:0] lim;
        wide = CLAMP_W'(v);
        lim  = CLAMP_W'({TIMER_WIDTH{1'b1}});
        if (wide > lim)
        begin
            clamp_target = {TIMER_WIDTH{1'b1}};
        end
        else
        begin
            clamp_target = TIMER_WIDTH'(wide);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/line_follow_search_sequencer.sv @@
// Top level of the line follow search sequencer with its register port.
//
// Each input beat is one tick carrying line_seen; each output beat carries the
// motor command, the phase that ran on that tick and the halted flag. Beats
// leave in the order they arrive, exactly one output beat per input beat.
// An input beat is registered, then one step of the phase and timer logic
// turns it into an output beat in the output register, and out_valid rises
// when that output register is loaded with the beat.
// One beat is taken every cycle while the
// receiver keeps out_ready high; the one step stage sets that figure.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and in_ready drops until the output beat is taken.
// The two registers search_ticks (address 0) and pause_ticks (address 4) are
// written over the APB port and should be written while no beat is in flight.
// Reset empties both registers, returns to follow mode facing right with the
// timer cleared, and loads search_ticks with 200 and pause_ticks with 0.
// Once every search fails the block reports halted until the next reset.
`default_nettype none

module line_follow_search_sequencer (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  line_seen,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output lfss_pkg::cmd_t                       motor_command,
    output lfss_pkg::phase_t                     phase,
    output logic                                 halted,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [lfss_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [lfss_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lfss_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import lfss_pkg::*;

    cfg_word_t search_ticks_reg;
    cfg_word_t pause_ticks_reg;
    logic      cfg_write;
    logic      reg_sel;

    logic      in_valid_reg;
    logic      line_seen_reg;
    logic      out_valid_reg;
    result_t   result_reg;
    state_t    state_reg;
    state_t    state_next;
    result_t   result_next;
    logic      out_advance;
    logic      step_fire;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[REG_SEL_BIT];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_ticks_reg <= SEARCH_TICKS_RESET;
            pause_ticks_reg  <= PAUSE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_SEARCH_TICKS)
            begin
                search_ticks_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                pause_ticks_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SEARCH_TICKS: prdata = APB_DATA_W'(search_ticks_reg);
            REG_PAUSE_TICKS:  prdata = APB_DATA_W'(pause_ticks_reg);
            default:          prdata = '0;
        endcase
    end

    assign out_advance = !out_valid_reg || out_ready;
    assign in_ready    = !in_valid_reg || out_advance;
    assign step_fire   = in_valid_reg && out_advance;

    lfss_step u_step (
        .line_seen    (line_seen_reg),
        .search_ticks (search_ticks_reg),
        .pause_ticks  (pause_ticks_reg),
        .cur          (state_reg),
        .nxt          (state_next),
        .res          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_FOLLOW;
            state_reg.after_pause <= PH_FOLLOW;
            state_reg.last_dir    <= DIR_RIGHT;
            state_reg.tick        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            line_seen_reg <= line_seen;
        end
        if (step_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_command = result_reg.cmd;
    assign phase         = result_reg.phase;
    assign halted        = result_reg.halted;

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HALTED |=> state_reg.phase == PH_HALTED)
        else $error("Sequencer left the halted phase without a reset.");

    a_follow_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_FOLLOW |-> state_reg.tick == '0)
        else $error("Timer is not clear in follow mode.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_advance |=> in_valid_reg && $stable(line_seen_reg))
        else $error("Held input beat was lost during an output stall.");

    a_forward_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motor_command == CMD_FORWARD
            |-> phase == PH_FOLLOW || phase == PH_SEARCH_FWD)
        else $error("Forward command issued outside follow or forward search.");

endmodule

`default_nettype wire

@@ rtl/lfss_step.sv @@
// One tick of the search sequencer: next state and the motor command, phase and halted flag.
`default_nettype none

module lfss_step (
    input  wire                  line_seen,
    input  lfss_pkg::cfg_word_t  search_ticks,
    input  lfss_pkg::cfg_word_t  pause_ticks,
    input  lfss_pkg::state_t     cur,
    output lfss_pkg::state_t     nxt,
    output lfss_pkg::result_t    res
);
    import lfss_pkg::*;

    timer_t swing_tgt;
    timer_t pause_tgt;
    timer_t tick_inc;
    logic   swing_done;
    logic   pause_done;
    logic   pause_zero;
    cmd_t   turn;

    assign swing_tgt  = (clamp_target(search_ticks) == '0) ? TIMER_WIDTH'(1)
                                                           : clamp_target(search_ticks);
    assign pause_tgt  = clamp_target(pause_ticks);
    assign tick_inc   = cur.tick + TIMER_WIDTH'(1);
    assign swing_done = tick_inc >= swing_tgt;
    assign pause_done = tick_inc >= pause_tgt;
    assign pause_zero = pause_ticks == '0;
    assign turn       = (cur.last_dir == DIR_RIGHT) ? CMD_RIGHT : CMD_LEFT;

    always_comb
    begin
        logic   go_enter;
        logic   go_finish;
        phase_t enter_ph;
        phase_t finish_ph;
        nxt       = cur;
        go_enter  = 1'b0;
        go_finish = 1'b0;
        enter_ph  = PH_FOLLOW;
        finish_ph = PH_FOLLOW;
        case (cur.phase)
            PH_FOLLOW:
            begin
                if (!line_seen)
                begin
                    go_enter = 1'b1;
                    enter_ph = PH_SEARCH_LAST;
                end
            end
            PH_SEARCH_LAST, PH_SEARCH_OTHER, PH_SEARCH_FWD:
            begin
                if (line_seen)
                begin
                    go_finish = 1'b1;
                    finish_ph = PH_FOLLOW;
                end
                else
                begin
                    nxt.tick = tick_inc;
                    if (swing_done)
                    begin
                        go_finish = 1'b1;
                        case (cur.phase)
                            PH_SEARCH_LAST:  finish_ph = PH_RETURN_A;
                            PH_SEARCH_OTHER: finish_ph = PH_RETURN_B;
                            default:         finish_ph = PH_HALTED;
                        endcase
                    end
                end
            end
            PH_RETURN_A, PH_RETURN_B:
            begin
                nxt.tick = tick_inc;
                if (swing_done)
                begin
                    go_finish = 1'b1;
                    finish_ph = (cur.phase == PH_RETURN_A) ? PH_SEARCH_OTHER : PH_SEARCH_FWD;
                end
            end
            PH_PAUSE:
            begin
                nxt.tick = tick_inc;
                if (pause_done)
                begin
                    go_enter = 1'b1;
                    enter_ph = cur.after_pause;
                end
            end
            default:
            begin
            end
        endcase

        if (go_finish)
        begin
            if (pause_zero)
            begin
                go_enter = 1'b1;
                enter_ph = finish_ph;
            end
            else
            begin
                nxt.after_pause = finish_ph;
                nxt.phase       = PH_PAUSE;
                nxt.tick        = '0;
            end
        end

        if (go_enter)
        begin
            nxt.phase = enter_ph;
            nxt.tick  = '0;
            if (enter_ph == PH_RETURN_A || enter_ph == PH_RETURN_B)
            begin
                nxt.last_dir = ~cur.last_dir;
            end
        end
    end

    always_comb
    begin
        res.phase  = cur.phase;
        res.halted = cur.phase == PH_HALTED;
        case (cur.phase)
            PH_FOLLOW:                       res.cmd = line_seen ? CMD_FORWARD : CMD_STOP;
            PH_SEARCH_LAST, PH_SEARCH_OTHER: res.cmd = line_seen ? CMD_STOP : turn;
            PH_SEARCH_FWD:                   res.cmd = line_seen ? CMD_STOP : CMD_FORWARD;
            PH_RETURN_A, PH_RETURN_B:        res.cmd = turn;
            default:                         res.cmd = CMD_STOP;
        endcase
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the line follow search sequencer: random ticks, checked results.
module tb;
    import lfss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  line_seen = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    cmd_t                  motor_command;
    phase_t                phase;
    logic                  halted;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_word_t   search_cfg  = SEARCH_TICKS_RESET;
    cfg_word_t   pause_cfg   = PAUSE_TICKS_RESET;
    state_t      track_state = '{PH_FOLLOW, PH_FOLLOW, DIR_RIGHT, '0};
    state_t      plan_state  = '{PH_FOLLOW, PH_FOLLOW, DIR_RIGHT, '0};
    bit          line_ticks_pending[$];
    result_t     expected_commands[$];
    int          errors         = 0;
    int          beats_checked  = 0;
    int          settings_used  = 0;
    int unsigned cycles         = 0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    logic [15:0] ready_pattern  = 16'hFFFF;

    line_follow_search_sequencer dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic timer_t swing_length();
        return (search_cfg == '0) ? timer_t'(1) : timer_t'(search_cfg);
    endfunction

    function automatic void enter_phase(inout state_t s, input phase_t next);
        s.phase = next;
        s.tick  = '0;
        if (next == PH_RETURN_A || next == PH_RETURN_B)
        begin
            s.last_dir = ~s.last_dir;
        end
    endfunction

    function automatic void end_swing(inout state_t s, input phase_t next);
        if (pause_cfg == '0)
        begin
            enter_phase(s, next);
        end
        else
        begin
            s.after_pause = next;
            s.phase       = PH_PAUSE;
            s.tick        = '0;
        end
    endfunction

    function automatic result_t step_sequencer(inout state_t s, input logic seen);
        phase_t  ran;
        cmd_t    turn;
        result_t r;
        ran   = s.phase;
        turn  = (s.last_dir == DIR_RIGHT) ? CMD_RIGHT : CMD_LEFT;
        r.cmd = CMD_STOP;
        case (ran)
            PH_FOLLOW:
            begin
                if (seen)
                begin
                    r.cmd = CMD_FORWARD;
                end
                else
                begin
                    enter_phase(s, PH_SEARCH_LAST);
                end
            end
            PH_SEARCH_LAST, PH_SEARCH_OTHER, PH_SEARCH_FWD:
            begin
                if (seen)
                begin
                    end_swing(s, PH_FOLLOW);
                end
                else
                begin
                    r.cmd  = (ran == PH_SEARCH_FWD) ? CMD_FORWARD : turn;
                    s.tick = s.tick + 1'b1;
                    if (s.tick >= swing_length())
                    begin
                        end_swing(s, (ran == PH_SEARCH_FWD) ? PH_HALTED : phase_t'(ran + 3'd1));
                    end
                end
            end
            PH_RETURN_A, PH_RETURN_B:
            begin
                r.cmd  = turn;
                s.tick = s.tick + 1'b1;
                if (s.tick >= swing_length())
                begin
                    end_swing(s, phase_t'(ran + 3'd1));
                end
            end
            PH_PAUSE:
            begin
                s.tick = s.tick + 1'b1;
                if (s.tick >= timer_t'(pause_cfg))
                begin
                    enter_phase(s, s.after_pause);
                end
            end
            default:
            begin
            end
        endcase
        r.phase  = ran;
        r.halted = (ran == PH_HALTED);
        return r;
    endfunction

    // Keeps the block out of the halted state unless told otherwise by turning the
    // last forward creep tick into a sighting.
    task automatic queue_tick(input logic seen, input bit keep_searching);
        logic next_seen;
        next_seen = seen;
        if (keep_searching && !seen && plan_state.phase == PH_SEARCH_FWD
            && timer_t'(plan_state.tick + 1'b1) >= swing_length())
        begin
            next_seen = 1'b1;
        end
        void'(step_sequencer(plan_state, next_seen));
        line_ticks_pending.push_back(next_seen);
    endtask

    task automatic write_register(input logic sel, input cfg_word_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({sel, {REG_SEL_BIT{1'b0}}});
        pwdata  <= APB_DATA_W'({$urandom, value});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_SEARCH_TICKS)
        begin
            search_cfg = value;
        end
        else
        begin
            pause_cfg = value;
        end
    endtask

    task automatic wait_drained();
        while (line_ticks_pending.size() != 0 || in_valid || expected_commands.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input cfg_word_t swing, input cfg_word_t pause);
        wait_drained();
        write_register(REG_SEARCH_TICKS, swing);
        write_register(REG_PAUSE_TICKS, pause);
        settings_used++;
    endtask

    initial
    begin
        int        random_items;
        int        count;
        int        pct;
        cfg_word_t s_val;
        cfg_word_t p_val;
        random_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);

        set_config(16'd1, 16'd1);
        repeat (10) queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);

        set_config(16'd0, 16'd0);
        repeat (3) queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);

        // Shorten the swing, then the pause, while each is under way.
        set_config(16'hFFFF, 16'hFFFF);
        repeat (3) queue_tick(1'b0, 1'b1);
        set_config(16'd1, 16'hFFFF);
        repeat (2) queue_tick(1'b0, 1'b1);
        set_config(16'd1, 16'd0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);

        while (random_items < 1150)
        begin
            case ($urandom_range(9))
                0:          s_val = 16'd0;
                1, 2, 3:    s_val = cfg_word_t'($urandom_range(1, 3));
                4, 5, 6, 7: s_val = cfg_word_t'($urandom_range(4, 12));
                8:          s_val = cfg_word_t'($urandom_range(13, 400));
                default:    s_val = cfg_word_t'(16'hFFFF - $urandom_range(2));
            endcase
            case ($urandom_range(5))
                0, 1:    p_val = 16'd0;
                2, 3:    p_val = cfg_word_t'($urandom_range(1, 3));
                4:       p_val = cfg_word_t'($urandom_range(4, 20));
                default: p_val = cfg_word_t'(16'hFFFF - $urandom_range(2));
            endcase
            case ($urandom_range(4))
                0:       pct = 2;
                1:       pct = 10;
                2:       pct = 30;
                3:       pct = 60;
                default: pct = 90;
            endcase
            set_config(s_val, p_val);
            count = $urandom_range(20, 90);
            repeat (count) queue_tick(logic'($urandom_range(99) < pct), 1'b1);
            random_items += count;
        end

        set_config(cfg_word_t'($urandom_range(1, 3)), cfg_word_t'($urandom_range(0, 2)));
        while (plan_state.phase != PH_HALTED)
        begin
            queue_tick(1'b0, 1'b0);
        end
        repeat (12) queue_tick(logic'($urandom_range(1)), 1'b0);

        wait_drained();
        $display("Checked %0d motor command beats across %0d register settings.",
                 beats_checked, settings_used);
        $display("Final search failure left the block halted: %0d.",
                 track_state.phase == PH_HALTED);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_commands.push_back(step_sequencer(track_state, line_seen));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (line_ticks_pending.size() != 0)
                begin
                    line_seen <= line_ticks_pending.pop_front();
                    in_valid  <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            ready_pattern <= 16'hFFFF;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_commands.size() == 0)
                begin
                    errors++;
                    $display("%0t: beat with no tick waiting: cmd %0d phase %0d halted %0d",
                             $time, motor_command, phase, halted);
                end
                else
                begin
                    want = expected_commands.pop_front();
                    beats_checked++;
                    if (motor_command !== want.cmd)
                    begin
                        errors++;
                        $display("%0t: motor_command expected %0d actual %0d",
                                 $time, want.cmd, motor_command);
                    end
                    if (phase !== want.phase)
                    begin
                        errors++;
                        $display("%0t: phase expected %0d actual %0d", $time, want.phase, phase);
                    end
                    if (halted !== want.halted)
                    begin
                        errors++;
                        $display("%0t: halted expected %0d actual %0d",
                                 $time, want.halted, halted);
                    end
                end
            end
            if (cycles % 48 == 0)
            begin
                case ($urandom_range(3))
                    0:       ready_pattern <= 16'hFFFF;
                    1:       ready_pattern <= 16'($urandom);
                    2:       ready_pattern <= 16'($urandom) | 16'($urandom);
                    default: ready_pattern <= 16'($urandom) & 16'($urandom);
                endcase
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
            out_ready <= ready_pattern[0];
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
